// File: sv/b2s_pkg.sv
// ----------------------------------------------------------------------------
// b2s_pkg
// Shared types, codes and the symbol alphabet for the byte to five-bit
// symbol encoder.
// ----------------------------------------------------------------------------
package b2s_pkg;

  // Operation carried in tuser on the input stream.
  typedef enum logic {
    OP_DATA  = 1'b0,
    OP_FLUSH = 1'b1
  } op_t;

  localparam logic [6:0] NEWLINE_CHAR  = 7'd10;
  localparam logic [7:0] RESET_LINE_LEN = 8'd80;
  localparam int         MAX_RESULTS   = 3;

  // One queued job: up to three output characters in order, and how many.
  typedef struct packed {
    logic [MAX_RESULTS-1:0][6:0] chars;
    logic [1:0]                  count;
  } job_t;

  // Maps a 5-bit group onto the custom alphabet.
  function automatic logic [6:0] map_symbol(input logic [4:0] v);
    logic [6:0] ch;
    unique case (v)
      5'd0:    ch = 7'd33;  // '!'
      5'd1:    ch = 7'd64;  // '@'
      5'd2:    ch = 7'd35;  // '#'
      5'd3:    ch = 7'd36;  // '$'
      5'd4:    ch = 7'd37;  // '%'
      5'd5:    ch = 7'd38;  // '&'
      default: ch = {2'b00, v} + 7'd91;  // 'a' for group value six
    endcase
    return ch;
  endfunction

endpackage

// File: sv/byte_to_five_bit_symbol_encoder_top.sv
// ----------------------------------------------------------------------------
// byte_to_five_bit_symbol_encoder_top
// Base32-style encoder with a custom alphabet and line breaking.
// ----------------------------------------------------------------------------
// Input stream (s_axis): one request is a data byte (tuser 0) or a flush
// (tuser 1). Bytes are shifted in MSB first; each full 5-bit group leaves
// as one ASCII character on the output stream (m_axis), with a newline
// after every line_length characters. A flush pads the pending bits into
// a last character, closes a non-empty line and clears the encoder state.
// tlast marks the final character caused by one input request; a flush
// with nothing pending and an empty line produces no output.
// The front part classifies one request per cycle, while the queue has room,
// into a job of up to three characters; a job queue feeds the back part,
// which sends one character per cycle while the receiver is ready. A byte
// thus gives one or two characters (three with a newline). The first
// character passes the queue and the back part's register before it is valid
// on m_axis. When the receiver stalls, the queue fills and s_axis_tready
// drops; the output holds until taken. Reset (rst, synchronous) empties the
// queue, clears the state and sets line_length to 80. cfg_wr_en writes
// line_length; the user must do so while the block is idle (not enforced).
// ----------------------------------------------------------------------------
module byte_to_five_bit_symbol_encoder_top #(
  parameter int QUEUE_DEPTH = 2
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       cfg_wr_en,
  input  logic [7:0] cfg_wr_data,     // line_length
  input  logic       s_axis_tvalid,
  output logic       s_axis_tready,
  input  logic [7:0] s_axis_tdata,    // [7:0] data_byte
  input  logic [0:0] s_axis_tuser,    // [0] operation
  output logic       m_axis_tvalid,
  input  logic       m_axis_tready,
  output logic [7:0] m_axis_tdata,    // [6:0] symbol, [7] zero
  output logic       m_axis_tlast
);
  import b2s_pkg::*;

  logic       fq_valid;
  logic       fq_ready;
  job_t       fq_job;
  logic       qb_valid;
  logic       qb_ready;
  job_t       qb_job;
  logic [6:0] out_char;

  b2s_front u_front (
    .clk        (clk),
    .rst        (rst),
    .cfg_wr_en  (cfg_wr_en),
    .cfg_wr_data(cfg_wr_data),
    .in_valid   (s_axis_tvalid),
    .in_ready   (s_axis_tready),
    .in_op      (s_axis_tuser[0]),
    .in_byte    (s_axis_tdata),
    .job_valid  (fq_valid),
    .job_ready  (fq_ready),
    .job        (fq_job)
  );

  b2s_queue #(
    .DEPTH(QUEUE_DEPTH)
  ) u_queue (
    .clk       (clk),
    .rst       (rst),
    .push_valid(fq_valid),
    .push_ready(fq_ready),
    .push_data (fq_job),
    .pop_valid (qb_valid),
    .pop_ready (qb_ready),
    .pop_data  (qb_job)
  );

  b2s_back u_back (
    .clk      (clk),
    .rst      (rst),
    .job_valid(qb_valid),
    .job_ready(qb_ready),
    .job      (qb_job),
    .out_valid(m_axis_tvalid),
    .out_ready(m_axis_tready),
    .out_char (out_char),
    .out_last (m_axis_tlast)
  );

  assign m_axis_tdata = {1'b0, out_char};

endmodule

// File: sv/b2s_front.sv
// ----------------------------------------------------------------------------
// b2s_front
// Accepts bytes and flush requests, cuts the bit stream into 5-bit groups,
// tracks the line column and hands each request's characters on as one job.
// ----------------------------------------------------------------------------
module b2s_front (
  input  logic          clk,
  input  logic          rst,
  input  logic          cfg_wr_en,
  input  logic [7:0]    cfg_wr_data,
  input  logic          in_valid,
  output logic          in_ready,
  input  logic          in_op,
  input  logic [7:0]    in_byte,
  output logic          job_valid,
  input  logic          job_ready,
  output b2s_pkg::job_t job
);
  import b2s_pkg::*;

  logic [7:0] line_length;
  logic [3:0] leftover_bits;
  logic [2:0] leftover_count;
  logic [7:0] line_column;

  logic [3:0] leftover_bits_next;
  logic [2:0] leftover_count_next;
  logic [7:0] line_column_next;
  logic       accept;

  // Effective line length: zero means 256, one is raised to two.
  logic [8:0] eff_len;
  always_comb begin
    if (line_length == 8'd0) begin
      eff_len = 9'd256;
    end else if (line_length == 8'd1) begin
      eff_len = 9'd2;
    end else begin
      eff_len = {1'b0, line_length};
    end
  end

  // Group extraction, column tracking and job assembly for one request.
  always_comb begin
    logic [11:0]      acc;
    logic [3:0]       total;
    logic [3:0]       new_cnt;
    logic [4:0]       mask;
    logic [1:0][4:0]  grp;
    logic [1:0]       n_grp;
    logic             close_nl;
    logic [8:0]       col;
    logic [1:0]       n;
    acc      = {leftover_bits, in_byte};
    total    = {1'b0, leftover_count} + 4'd8;
    grp      = '0;
    n_grp    = 2'd0;
    close_nl = 1'b0;
    new_cnt  = 4'd0;
    mask     = 5'd0;
    leftover_bits_next  = 4'd0;
    leftover_count_next = 3'd0;

    if (in_op == OP_DATA) begin
      grp[0] = 5'(acc >> (total - 4'd5));
      if (total >= 4'd10) begin
        grp[1]  = 5'(acc >> (total - 4'd10));
        n_grp   = 2'd2;
        new_cnt = total - 4'd10;
      end else begin
        n_grp   = 2'd1;
        new_cnt = total - 4'd5;
      end
      mask = (5'd1 << new_cnt) - 5'd1;
      leftover_bits_next  = acc[3:0] & mask[3:0];
      leftover_count_next = new_cnt[2:0];
    end else begin
      // Flush: zero-pad the pending bits into a final group.
      grp[0]   = 5'({1'b0, leftover_bits} << (3'd5 - leftover_count));
      n_grp    = (leftover_count != 3'd0) ? 2'd1 : 2'd0;
      close_nl = 1'b1;
    end

    // Emit the groups, with a newline wherever the line fills up.
    job.chars = '0;
    n   = 2'd0;
    col = {1'b0, line_column};
    for (int i = 0; i < 2; i++) begin
      if (2'(i) < n_grp) begin
        job.chars[n] = map_symbol(grp[i]);
        n   = n + 2'd1;
        col = col + 9'd1;
        if (col >= eff_len) begin
          job.chars[n] = NEWLINE_CHAR;
          n   = n + 2'd1;
          col = 9'd0;
        end
      end
    end
    if (close_nl && col != 9'd0) begin
      job.chars[n] = NEWLINE_CHAR;
      n = n + 2'd1;
    end
    job.count = n;
    line_column_next = close_nl ? 8'd0 : col[7:0];
  end

  assign in_ready  = job_ready;
  assign accept    = in_valid && job_ready;
  assign job_valid = accept && (job.count != 2'd0);

  // Configuration register and encoder state.
  always_ff @(posedge clk) begin
    if (rst) begin
      line_length    <= RESET_LINE_LEN;
      leftover_bits  <= 4'd0;
      leftover_count <= 3'd0;
      line_column    <= 8'd0;
    end else begin
      if (cfg_wr_en) begin
        line_length <= cfg_wr_data;
      end
      if (accept) begin
        leftover_bits  <= leftover_bits_next;
        leftover_count <= leftover_count_next;
        line_column    <= line_column_next;
      end
    end
  end

endmodule

// File: sv/b2s_queue.sv
// ----------------------------------------------------------------------------
// b2s_queue
// Small job queue between the front and back parts of the encoder.
// ----------------------------------------------------------------------------
module b2s_queue #(
  parameter int DEPTH = 2
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          push_valid,
  output logic          push_ready,
  input  b2s_pkg::job_t push_data,
  output logic          pop_valid,
  input  logic          pop_ready,
  output b2s_pkg::job_t pop_data
);
  import b2s_pkg::*;

  localparam int PtrW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CntW = $clog2(DEPTH + 1);

  job_t            mem [DEPTH];
  logic [PtrW-1:0] wr_ptr;
  logic [PtrW-1:0] rd_ptr;
  logic [CntW-1:0] count;
  logic            do_push;
  logic            do_pop;

  assign push_ready = (count != CntW'(DEPTH));
  assign pop_valid  = (count != '0);
  assign pop_data   = mem[rd_ptr];
  assign do_push    = push_valid && push_ready;
  assign do_pop     = pop_valid && pop_ready;

  // Storage writes.
  always_ff @(posedge clk) begin
    if (do_push) begin
      mem[wr_ptr] <= push_data;
    end
  end

  // Pointers and fill count.
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == PtrW'(DEPTH - 1)) ? '0 : wr_ptr + PtrW'(1);
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == PtrW'(DEPTH - 1)) ? '0 : rd_ptr + PtrW'(1);
      end
      if (do_push && !do_pop) begin
        count <= count + CntW'(1);
      end else if (do_pop && !do_push) begin
        count <= count - CntW'(1);
      end
    end
  end

endmodule

// File: sv/b2s_back.sv
// ----------------------------------------------------------------------------
// b2s_back
// Takes jobs from the queue and plays their characters out one character per
// cycle while the receiver is ready, marking the final character of each job.
// ----------------------------------------------------------------------------
module b2s_back (
  input  logic          clk,
  input  logic          rst,
  input  logic          job_valid,
  output logic          job_ready,
  input  b2s_pkg::job_t job,
  output logic          out_valid,
  input  logic          out_ready,
  output logic [6:0]    out_char,
  output logic          out_last
);
  import b2s_pkg::*;

  job_t       cur;
  logic       cur_valid;
  logic [1:0] idx;

  assign out_valid = cur_valid;
  assign out_char  = cur.chars[idx];
  assign out_last  = (idx == cur.count - 2'd1);

  // A new job loads when nothing is held or the held job just finished.
  assign job_ready = !cur_valid || (out_ready && out_last);

  always_ff @(posedge clk) begin
    if (rst) begin
      cur_valid <= 1'b0;
      idx       <= 2'd0;
    end else if (job_ready) begin
      cur_valid <= job_valid;
      idx       <= 2'd0;
    end else if (out_ready) begin
      idx <= idx + 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (job_ready && job_valid) begin
      cur <= job;
    end
  end

endmodule

// File: sv/b2s_checker.sv
// ----------------------------------------------------------------------------
// b2s_checker
// Port-level checks for the byte to five-bit symbol encoder.
// ----------------------------------------------------------------------------
module b2s_checker (
  input logic       clk,
  input logic       rst,
  input logic       s_axis_tready,
  input logic       m_axis_tvalid,
  input logic       m_axis_tready,
  input logic [7:0] m_axis_tdata,
  input logic       m_axis_tlast
);

  // Reset leaves no character pending on the output.
  a_reset_out_idle: assert property (@(posedge clk) rst |=> !m_axis_tvalid)
    else $error("output valid right after reset");

  // Reset leaves the job queue empty, so input is taken at once.
  a_reset_in_ready: assert property (@(posedge clk) rst |=> s_axis_tready)
    else $error("input not ready right after reset");

  // A stalled character holds its value and its end marker.
  a_stall_hold: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && !m_axis_tready |=>
      m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tlast))
    else $error("output changed while stalled");

  // Every character is a newline or a member of the alphabet.
  a_alphabet: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid |->
      (m_axis_tdata == 8'd10) || (m_axis_tdata == 8'd33) ||
      (m_axis_tdata == 8'd64) || (m_axis_tdata == 8'd35) ||
      (m_axis_tdata == 8'd36) || (m_axis_tdata == 8'd37) ||
      (m_axis_tdata == 8'd38) ||
      ((m_axis_tdata >= 8'd97) && (m_axis_tdata <= 8'd122)))
    else $error("character outside the alphabet");

endmodule

bind byte_to_five_bit_symbol_encoder_top b2s_checker u_b2s_checker (
  .clk          (clk),
  .rst          (rst),
  .s_axis_tready(s_axis_tready),
  .m_axis_tvalid(m_axis_tvalid),
  .m_axis_tready(m_axis_tready),
  .m_axis_tdata (m_axis_tdata),
  .m_axis_tlast (m_axis_tlast)
);

// File: tb/sv/byte_to_five_bit_symbol_encoder_top_tb.sv
// ----------------------------------------------------------------------------
// byte_to_five_bit_symbol_encoder_top_tb
// Self-checking testbench for the byte to five-bit symbol encoder.
// ----------------------------------------------------------------------------
// A short directed table covers the byte extremes, flushes with and without
// pending bits, every alphabet range and the line length corner cases:
// zero, one, the maximum and a length lowered in the middle of a line.
// Random bytes and flushes follow in phases with different line lengths.
// Every accepted request runs through a bit-level predictor of the encoder.
// Every character on the output stream is compared with the oldest
// predicted one. Both streams idle at random, and the receiver once holds
// off long enough to stall the input.
// ----------------------------------------------------------------------------
module byte_to_five_bit_symbol_encoder_top_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import b2s_pkg::*;

  localparam int WATCHDOG_LIMIT = 3000;
  localparam int LONG_HOLD      = 300;
  localparam int DRAIN_CYCLES   = 10;
  localparam int PHASE_ITEMS    = 17;

  // Characters that can be read off directly in the directed table.
  localparam logic [6:0] CH_BANG = 7'd33;   // '!'
  localparam logic [6:0] CH_K    = 7'd107;  // 'k'
  localparam logic [6:0] CH_Z    = 7'd122;  // 'z'

  typedef enum logic {
    ROW_ITEM   = 1'b0,
    ROW_CONFIG = 1'b1
  } row_kind_t;

  // One row of stimulus: a request or a line length write, with optional
  // characters typed in by hand.
  typedef struct packed {
    row_kind_t       kind;
    op_t             op;
    logic [7:0]      value;
    logic            typed;
    logic [1:0]      n_exp;
    logic [2:0][6:0] exp_chars;
  } stim_row_t;

  typedef struct packed {
    logic [6:0] symbol;
    logic       last;
  } enc_result_t;

  logic       clk = 1'b0;
  logic       rst;
  logic       cfg_wr_en;
  logic [7:0] cfg_wr_data;
  logic       s_axis_tvalid;
  logic       s_axis_tready;
  logic [7:0] s_axis_tdata;
  logic [0:0] s_axis_tuser;
  logic       m_axis_tvalid;
  logic       m_axis_tready;
  logic [7:0] m_axis_tdata;
  logic       m_axis_tlast;

  // Predictor state.
  logic [7:0] line_len_reg;
  logic [3:0] enc_bits;
  logic [2:0] enc_count;
  logic [7:0] enc_column;

  logic [6:0]  step_batch[$];
  enc_result_t expected_symbols[$];
  stim_row_t   directed_rows[$];

  int mismatch_count = 0;
  int stall_cycles   = 0;
  int rx_idle_pct    = 0;
  int tx_idle_pct    = 0;
  int rx_hold_cycles = 0;
  int rx_gap         = 0;

  byte_to_five_bit_symbol_encoder_top u_top (
    .clk           (clk),
    .rst           (rst),
    .cfg_wr_en     (cfg_wr_en),
    .cfg_wr_data   (cfg_wr_data),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Picks an idle gap: mostly none, sometimes short, rarely long.
  function automatic int pick_gap(input int pct);
    if ($urandom_range(99) >= pct) return 0;
    if ($urandom_range(9) == 0) return $urandom_range(40, 10);
    return $urandom_range(3, 1);
  endfunction

  // Emits one 5-bit group as a character and breaks the line when full.
  function automatic void emit_group(input logic [4:0] grp);
    logic [6:0] ch;
    int         eff;
    int         col;
    case (grp)
      5'd0:    ch = 7'd33;
      5'd1:    ch = 7'd64;
      5'd2:    ch = 7'd35;
      5'd3:    ch = 7'd36;
      5'd4:    ch = 7'd37;
      5'd5:    ch = 7'd38;
      default: ch = 7'd97 + 7'(grp) - 7'd6;
    endcase
    step_batch = {step_batch, ch};
    // Zero means 256; one is widened to two to keep three results per request.
    if (line_len_reg == 8'd0) eff = 256;
    else if (line_len_reg == 8'd1) eff = 2;
    else eff = int'(line_len_reg);
    col = int'(enc_column) + 1;
    if (col >= eff) begin
      step_batch = {step_batch, NEWLINE_CHAR};
      col = 0;
    end
    enc_column = col[7:0];
  endfunction

  // Computes the characters caused by one accepted request.
  function automatic void predict_encoding(input op_t op, input logic [7:0] b);
    logic [11:0] acc;
    logic [11:0] mask;
    int          total;
    step_batch.delete();
    if (op == OP_DATA) begin
      acc   = {enc_bits, b};
      total = int'(enc_count) + 8;
      while (total >= 5) begin
        emit_group(5'((acc >> (total - 5)) & 12'd31));
        total -= 5;
      end
      mask      = (12'd1 << total) - 12'd1;
      enc_bits  = 4'(acc & mask);
      enc_count = 3'(total);
    end else begin
      // Pad the pending bits with zeros, then close a non-empty line.
      if (enc_count != 3'd0) emit_group(5'({1'b0, enc_bits} << (5 - enc_count)));
      if (enc_column != 8'd0) step_batch = {step_batch, NEWLINE_CHAR};
      enc_bits   = 4'd0;
      enc_count  = 3'd0;
      enc_column = 8'd0;
    end
  endfunction

  function automatic void add_item(input op_t op, input logic [7:0] b);
    stim_row_t r;
    r       = '0;
    r.kind  = ROW_ITEM;
    r.op    = op;
    r.value = b;
    directed_rows = {directed_rows, r};
  endfunction

  function automatic void add_typed(input op_t op, input logic [7:0] b,
                                    input logic [1:0] n,
                                    input logic [6:0] c0, input logic [6:0] c1,
                                    input logic [6:0] c2);
    stim_row_t r;
    r           = '0;
    r.kind      = ROW_ITEM;
    r.op        = op;
    r.value     = b;
    r.typed     = 1'b1;
    r.n_exp     = n;
    r.exp_chars = {c2, c1, c0};
    directed_rows = {directed_rows, r};
  endfunction

  function automatic void add_config(input logic [7:0] v);
    stim_row_t r;
    r       = '0;
    r.kind  = ROW_CONFIG;
    r.value = v;
    directed_rows = {directed_rows, r};
  endfunction

  task automatic report_mismatch(input string what, input logic [7:0] got,
                                 input logic [7:0] want);
    $display("MISMATCH %s: got %0d, expected %0d at %0t", what, got, want, $realtime);
    mismatch_count++;
  endtask

  // Drops the request valid over the given gap and drives noise meanwhile.
  task automatic sender_gap(input int n);
    if (n > 0) begin
      @(negedge clk);
      s_axis_tvalid <= 1'b0;
      s_axis_tdata  <= 8'($urandom);
      s_axis_tuser  <= 1'($urandom);
      repeat (n - 1) @(negedge clk);
    end
  endtask

  // Offers one request, waits for acceptance and queues its characters.
  task automatic send_request(input stim_row_t row);
    enc_result_t r;
    int          i;
    @(negedge clk);
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= row.value;
    s_axis_tuser  <= row.op;
    @(posedge clk);
    while (!s_axis_tready) @(posedge clk);
    predict_encoding(row.op, row.value);
    if (!row.typed) begin
      for (i = 0; i < step_batch.size(); i++) begin
        r.symbol = step_batch[i];
        r.last   = (i == step_batch.size() - 1);
        expected_symbols = {expected_symbols, r};
      end
    end else begin
      for (i = 0; i < int'(row.n_exp); i++) begin
        r.symbol = row.exp_chars[i];
        r.last   = (i == int'(row.n_exp) - 1);
        expected_symbols = {expected_symbols, r};
      end
    end
  endtask

  // Stops offering requests until every predicted character has arrived.
  task automatic drain_results();
    @(negedge clk);
    s_axis_tvalid <= 1'b0;
    while (expected_symbols.size() != 0) @(posedge clk);
  endtask

  // Writes line_length once the encoder is idle, then updates the predictor.
  task automatic write_line_length(input logic [7:0] v);
    drain_results();
    // A flush on an empty line leaves nothing to wait for, so add slack.
    repeat (DRAIN_CYCLES) @(posedge clk);
    @(negedge clk);
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= v;
    @(negedge clk);
    cfg_wr_en   <= 1'b0;
    line_len_reg = v;
  endtask

  // Receiver: random back-pressure plus an occasional long hold-off.
  initial begin
    m_axis_tready = 1'b0;
    forever begin
      @(negedge clk);
      if (rx_hold_cycles > 0) begin
        m_axis_tready <= 1'b0;
        rx_hold_cycles--;
      end else if (rx_gap > 0) begin
        m_axis_tready <= 1'b0;
        rx_gap--;
      end else begin
        m_axis_tready <= 1'b1;
        rx_gap = pick_gap(rx_idle_pct);
      end
    end
  end

  // Output checker: each character against the oldest prediction.
  always @(posedge clk) begin : check_output
    enc_result_t want;
    if (!rst && m_axis_tvalid && m_axis_tready) begin
      if (expected_symbols.size() == 0) begin
        report_mismatch("unexpected character", m_axis_tdata, 8'd0);
      end else begin
        want = expected_symbols.pop_front();
        if (m_axis_tdata !== {1'b0, want.symbol})
          report_mismatch("symbol", m_axis_tdata, {1'b0, want.symbol});
        if (m_axis_tlast !== want.last)
          report_mismatch("tlast", {7'd0, m_axis_tlast}, {7'd0, want.last});
      end
    end
  end

  // Watchdog on cycles with no handshake on either stream.
  always @(posedge clk) begin
    if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
      stall_cycles <= 0;
    else
      stall_cycles <= stall_cycles + 1;
    if (stall_cycles >= WATCHDOG_LIMIT) begin
      $display("watchdog: no handshake for %0d cycles", stall_cycles);
      $display("Some tests failed");
      $finish;
    end
  end

  // Main stimulus.
  initial begin
    stim_row_t row;
    int        phase_len  [0:5];
    int        phase_tx   [0:5];
    int        phase_rx   [0:5];
    int        p;
    int        k;

    rst           = 1'b1;
    cfg_wr_en     = 1'b0;
    cfg_wr_data   = 8'd0;
    s_axis_tvalid = 1'b0;
    s_axis_tdata  = 8'd0;
    s_axis_tuser  = 1'b0;
    line_len_reg  = RESET_LINE_LEN;
    enc_bits      = 4'd0;
    enc_count     = 3'd0;
    enc_column    = 8'd0;

    // Directed table. From reset: zero byte, padded flush, empty flush.
    add_typed(OP_DATA,  8'h00, 2'd1, CH_BANG, 7'd0, 7'd0);
    add_typed(OP_FLUSH, 8'h00, 2'd2, CH_BANG, NEWLINE_CHAR, 7'd0);
    add_typed(OP_FLUSH, 8'hFF, 2'd0, 7'd0, 7'd0, 7'd0);
    // All ones, then a flush of the single pending bit.
    add_typed(OP_DATA,  8'hFF, 2'd1, CH_Z, 7'd0, 7'd0);
    add_typed(OP_DATA,  8'hFF, 2'd2, CH_Z, CH_Z, 7'd0);
    add_typed(OP_FLUSH, 8'h00, 2'd2, CH_K, NEWLINE_CHAR, 7'd0);
    // Several punctuation codes, the start of the letters, flush with data.
    add_item(OP_DATA,  8'h08);
    add_item(OP_DATA,  8'h10);
    add_item(OP_DATA,  8'h18);
    add_item(OP_DATA,  8'h20);
    add_item(OP_DATA,  8'h28);
    add_item(OP_DATA,  8'h30);
    add_item(OP_FLUSH, 8'hA5);
    // Longest line, then lowered below the current column.
    add_config(8'd255);
    add_item(OP_DATA,  8'h5A);
    add_item(OP_DATA,  8'hA5);
    add_item(OP_DATA,  8'h3C);
    add_item(OP_DATA,  8'hC3);
    add_config(8'd2);
    add_item(OP_DATA,  8'h7E);
    add_item(OP_DATA,  8'h81);
    add_item(OP_FLUSH, 8'h00);
    // Length one behaves as two; length zero as 256.
    add_config(8'd1);
    add_item(OP_DATA,  8'hFF);
    add_item(OP_DATA,  8'h00);
    add_item(OP_DATA,  8'hFF);
    add_item(OP_FLUSH, 8'h00);
    add_config(8'd0);
    add_item(OP_DATA,  8'h12);
    add_item(OP_FLUSH, 8'h00);

    repeat (11) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    rx_idle_pct = 20;
    tx_idle_pct = 20;
    foreach (directed_rows[i]) begin
      if (directed_rows[i].kind == ROW_CONFIG) begin
        write_line_length(directed_rows[i].value);
      end else begin
        sender_gap(pick_gap(tx_idle_pct));
        send_request(directed_rows[i]);
      end
    end

    // Random phases: line length, sender and receiver idle percentages.
    phase_len[0] = 80;  phase_tx[0] = 0;  phase_rx[0] = 0;
    phase_len[1] = 255; phase_tx[1] = 0;  phase_rx[1] = 10;
    phase_len[2] = 2;   phase_tx[2] = 30; phase_rx[2] = 30;
    phase_len[3] = 0;   phase_tx[3] = 20; phase_rx[3] = 40;
    phase_len[4] = 1;   phase_tx[4] = 40; phase_rx[4] = 20;
    phase_len[5] = $urandom_range(254, 3);
    phase_tx[5] = 25;   phase_rx[5] = 25;

    for (p = 0; p < 6; p++) begin
      write_line_length(8'(phase_len[p]));
      rx_idle_pct = phase_rx[p];
      tx_idle_pct = phase_tx[p];
      // Long receiver hold-off while the sender keeps offering requests.
      if (p == 1) begin
        @(posedge clk);
        rx_hold_cycles = LONG_HOLD;
      end
      for (k = 0; k < PHASE_ITEMS; k++) begin
        row       = '0;
        row.kind  = ROW_ITEM;
        row.op    = ($urandom_range(9) == 0) ? OP_FLUSH : OP_DATA;
        row.value = 8'($urandom);
        // Sender pause until every pending character has come out.
        if (p == 3 && k == PHASE_ITEMS / 2) drain_results();
        sender_gap(pick_gap(tx_idle_pct));
        send_request(row);
      end
    end

    drain_results();
    repeat (20) @(posedge clk);
    if (mismatch_count == 0 && expected_symbols.size() == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
